>>> src/sfpd_pkg.sv
// Shared types, constants and helpers for the static foreground pixel detector.
// No dependencies; compiled first.
`default_nettype none

package sfpd_pkg;

	localparam int unsigned PIXELS            = 65536;   // power of two
	localparam int unsigned ADDR_BITS         = $clog2(PIXELS);
	localparam int unsigned COUNT_BITS        = 10;
	localparam int unsigned SECONDS_TO_FRAMES = 10;
	localparam int unsigned CFG_INDEX_BITS    = 2;
	localparam int unsigned CFG_DATA_BITS     = 8;

	typedef logic [ADDR_BITS-1:0]      addr_t;
	typedef logic [COUNT_BITS-1:0]     count_t;
	typedef logic [15:0]               index_t;
	typedef logic [7:0]                pixel_t;
	typedef logic [6:0]                seconds_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

	localparam count_t     COUNT_MAX          = '1;
	localparam seconds_t   WINDOW_SECONDS_RST = 7'd1;
	localparam pixel_t     THRESHOLD_RST      = 8'd50;

	localparam cfg_index_t REG_WINDOW_SECONDS = 2'd0;
	localparam cfg_index_t REG_DIFF_THRESHOLD = 2'd1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FRAME = 1'b1;

	// raster index to memory address (PIXELS is a power of two)
	function automatic addr_t pixel_addr(input index_t idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[ADDR_BITS-1:0];
	endfunction

	// window length in frames, capped at the counter range
	function automatic count_t window_len(input seconds_t secs);
		logic [31:0] frames;
		frames = 32'(secs) * SECONDS_TO_FRAMES;
		return (frames > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(frames);
	endfunction

endpackage

`default_nettype wire

>>> src/sfpd_if.sv
// Handshake channel interfaces: pixel input, result output, config write.
// Depends on sfpd_pkg.
`default_nettype none

interface sfpd_pix_if;
	import sfpd_pkg::*;
	logic   valid;
	logic   ready;
	logic   req_type;
	index_t pixel_index;
	pixel_t pixel_value;
	logic   last_pixel;

	modport source (output valid, req_type, pixel_index, pixel_value, last_pixel,
		input ready);
	modport sink (input valid, req_type, pixel_index, pixel_value, last_pixel,
		output ready);
endinterface

interface sfpd_res_if;
	import sfpd_pkg::*;
	logic   valid;
	logic   ready;
	index_t out_index;
	logic   foreground;
	logic   static_object;
	logic   window_full;

	modport source (output valid, out_index, foreground, static_object, window_full,
		input ready);
	modport sink (input valid, out_index, foreground, static_object, window_full,
		output ready);
endinterface

interface sfpd_cfg_if;
	import sfpd_pkg::*;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/sfpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sfpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a same-address write in this cycle is not seen
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> src/static_foreground_pixel_detector.sv
// Static foreground pixel detector: top level.
// Pipeline: stage 1 register (RAM read in flight), then the output register.
// Throughput: one word per cycle while res_out is not stalled; the background and
// run-counter RAMs write back as stage 1 advances; a same-pixel follow-on word takes forwarded data.
// Reset: async active-low clears valids, frame count and config (window 1 s,
// threshold 50). RAM contents are not cleared; background is undefined until loaded.
`default_nettype none

module static_foreground_pixel_detector (
	input  logic            clk,
	input  logic            arst_n,
	sfpd_pix_if.sink        pix_in,
	sfpd_res_if.source      res_out,
	sfpd_cfg_if.sink        cfg
);
	import sfpd_pkg::*;

	// ---------------- configuration ----------------
	seconds_t window_seconds_q;
	pixel_t   diff_threshold_q;
	count_t   win_len;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_seconds_q <= WINDOW_SECONDS_RST;
			diff_threshold_q <= THRESHOLD_RST;
		end else if (cfg.valid) begin
			// zero seconds is ignored; unknown indexes do nothing
			if (cfg.index == REG_WINDOW_SECONDS && cfg.data[6:0] != '0) begin
				window_seconds_q <= cfg.data[6:0];
			end else if (cfg.index == REG_DIFF_THRESHOLD) begin
				diff_threshold_q <= cfg.data;
			end
		end
	end

	assign win_len = window_len(window_seconds_q);

	// ---------------- handshake / stage control ----------------
	logic   in_acc;
	logic   s1_valid_q;
	logic   s1_adv;
	logic   out_valid_q;

	assign s1_adv       = s1_valid_q && (!out_valid_q || res_out.ready);
	assign pix_in.ready = !s1_valid_q || s1_adv;
	assign in_acc       = pix_in.valid && pix_in.ready;

	// ---------------- stage 1 word (RAM read in flight) ----------------
	logic   req_type_s1;
	index_t index_s1;
	addr_t  addr_s1;
	pixel_t pixel_s1;
	logic   last_s1;
	addr_t  in_addr;

	assign in_addr = pixel_addr(pix_in.pixel_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_in.ready) begin
			s1_valid_q <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_type_s1 <= pix_in.req_type;
			index_s1    <= pix_in.pixel_index;
			addr_s1     <= in_addr;
			pixel_s1    <= pix_in.pixel_value;
			last_s1     <= pix_in.last_pixel;
		end
	end

	// ---------------- memories ----------------
	logic   bg_we;
	logic   cnt_we;
	pixel_t bg_rdata;
	count_t cnt_rdata;
	count_t cnt_new;

	assign bg_we  = s1_adv && req_type_s1 == REQ_LOAD;
	assign cnt_we = s1_adv && req_type_s1 == REQ_FRAME;

	sfpd_ram #(.WIDTH(8), .DEPTH(PIXELS)) u_bg_ram (
		.clk   (clk),
		.we    (bg_we),
		.waddr (addr_s1),
		.wdata (pixel_s1),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (bg_rdata)
	);

	sfpd_ram #(.WIDTH(COUNT_BITS), .DEPTH(PIXELS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (addr_s1),
		.wdata (cnt_new),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (cnt_rdata)
	);

	// A word read in the same edge as the previous word's write-back gets the
	// stale entry; capture that write here and substitute it in stage 1.
	logic   fwd_bg_hit_q;
	logic   fwd_cnt_hit_q;
	pixel_t fwd_bg_q;
	count_t fwd_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_bg_hit_q  <= 1'b0;
			fwd_cnt_hit_q <= 1'b0;
		end else if (in_acc) begin
			fwd_bg_hit_q  <= bg_we && addr_s1 == in_addr;
			fwd_cnt_hit_q <= cnt_we && addr_s1 == in_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fwd_bg_q  <= pixel_s1;
			fwd_cnt_q <= cnt_new;
		end
	end

	// ---------------- stage 1 compute ----------------
	pixel_t bg_cur;
	count_t cnt_old;
	pixel_t abs_diff;
	logic   fg;
	logic   win_full;
	logic   frames_zero;
	count_t frames_q;

	assign bg_cur      = fwd_bg_hit_q  ? fwd_bg_q  : bg_rdata;
	assign cnt_old     = fwd_cnt_hit_q ? fwd_cnt_q : cnt_rdata;
	assign abs_diff    = (pixel_s1 > bg_cur) ? pixel_s1 - bg_cur : bg_cur - pixel_s1;
	assign fg          = abs_diff > diff_threshold_q;
	assign frames_zero = frames_q == '0;
	assign win_full    = ({1'b0, frames_q} + 1'b1) >= {1'b0, win_len};

	always_comb begin
		// first frame after reset or a background load writes without using the old count
		priority if (frames_zero) begin
			cnt_new = fg ? count_t'(1) : '0;
		end else if (fg) begin
			cnt_new = (cnt_old >= win_len) ? win_len : cnt_old + 1'b1;
		end else begin
			cnt_new = '0;
		end
	end

	// completed-frame count, cleared by any background load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
		end else if (s1_adv) begin
			if (req_type_s1 == REQ_LOAD) begin
				frames_q <= '0;
			end else if (last_s1 && frames_q != COUNT_MAX) begin
				frames_q <= frames_q + 1'b1;
			end
		end
	end

	// ---------------- output register ----------------
	index_t out_index_q;
	logic   fg_q;
	logic   static_q;
	logic   full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_index_q <= index_s1;
			if (req_type_s1 == REQ_LOAD) begin
				fg_q     <= 1'b0;
				static_q <= 1'b0;
				full_q   <= 1'b0;
			end else begin
				fg_q     <= fg;
				static_q <= win_full && cnt_new >= win_len;
				full_q   <= win_full;
			end
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.out_index     = out_index_q;
	assign res_out.foreground    = fg_q;
	assign res_out.static_object = static_q;
	assign res_out.window_full   = full_q;

	// ---------------- assertions ----------------
	a_load_clears_frames: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && req_type_s1 == REQ_LOAD |=> frames_q == '0)
		else $error("frame count not cleared by load");

	a_static_needs_full_fg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && static_q |-> full_q && fg_q)
		else $error("static result without full window and foreground");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		window_seconds_q != '0)
		else $error("window seconds became zero");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted word lost before stage 1");

endmodule

`default_nettype wire
